/* design/kcpm_pkg.sv */
// kcpm_pkg: shared types, codes, constants and the crc step function for the
// keyfile crc pool mixer. No dependencies; every other design file uses it.
`timescale 1ns / 1ps

package kcpm_pkg;

    // payload widths of the channels
    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 6;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CRC_W      = 32;

    // default pool size
    localparam int POOL_BYTES_DEF = 64;

    // crc-32, reflected form
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // length register reset values
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 25'd1048576;
    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 25'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_END   = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // commands from the control path to the pool cells
    typedef struct packed {
        logic wr;
        logic mix;
    } t_pool_cmd;

    // one keyfile byte through the reflected crc, eight bit steps
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] v;
        v = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < 8; i++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

/* design/kcpm_in_if.sv */
// kcpm_in_if: input item channel (kind, pool index, data byte) with valid/ready.
// Depends on kcpm_pkg for the field widths.
`timescale 1ns / 1ps

interface kcpm_in_if;
    logic                              valid;
    logic                              ready;
    logic [kcpm_pkg::KIND_W-1:0]       kind;
    logic [kcpm_pkg::INDEX_W-1:0]      pool_index;
    logic [kcpm_pkg::BYTE_W-1:0]       data_byte;

    modport source (output valid, output kind, output pool_index, output data_byte,
                    input ready);
    modport sink   (input valid, input kind, input pool_index, input data_byte,
                    output ready);
endinterface

/* design/kcpm_out_if.sv */
// kcpm_out_if: result item channel (read byte, status) with valid/ready.
// Depends on kcpm_pkg for the field widths.
`timescale 1ns / 1ps

interface kcpm_out_if;
    logic                              valid;
    logic                              ready;
    logic [kcpm_pkg::BYTE_W-1:0]       read_byte;
    logic [kcpm_pkg::STATUS_W-1:0]     status;

    modport source (output valid, output read_byte, output status, input ready);
    modport sink   (input valid, input read_byte, input status, output ready);
endinterface

/* design/kcpm_cfg_if.sv */
// kcpm_cfg_if: configuration write channel (register index, write data).
// Depends on kcpm_pkg for the field widths.
`timescale 1ns / 1ps

interface kcpm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kcpm_pkg::CFG_IDX_W-1:0]    index;
    logic [kcpm_pkg::LEN_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/kcpm_pool.sv */
// kcpm_pool: the key pool as a row of byte cells, each with its own adder,
// plus the rotating mix positions and the readback mux. Depends on kcpm_pkg.
`timescale 1ns / 1ps

module kcpm_pool #(
    parameter int POOL_BYTES = kcpm_pkg::POOL_BYTES_DEF,
    localparam int PW = $clog2(POOL_BYTES)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kcpm_pkg::t_pool_cmd            i_cmd,
    input  logic [kcpm_pkg::INDEX_W-1:0]   i_index,
    input  logic [kcpm_pkg::BYTE_W-1:0]    i_wdata,
    input  logic [PW-1:0]                  i_pos,
    input  logic [kcpm_pkg::CRC_W-1:0]     i_crc,
    output logic [PW-1:0]                  o_next_pos,
    output logic [kcpm_pkg::BYTE_W-1:0]    o_rdata
);

    localparam logic [PW:0] POOL_END = (PW+1)'(POOL_BYTES);

    logic [kcpm_pkg::BYTE_W-1:0] r_pool [POOL_BYTES];
    logic [kcpm_pkg::BYTE_W-1:0] n_pool [POOL_BYTES];
    logic [PW-1:0]               w_pos  [4];

    // four consecutive positions from the base, each wrapping on its own
    always_comb begin
        logic [PW:0] inc;
        w_pos[0] = i_pos;
        for (int k = 1; k < 4; k++) begin
            inc = {1'b0, w_pos[k-1]} + 1'b1;
            w_pos[k] = (inc == POOL_END) ? '0 : inc[PW-1:0];
        end
        inc = {1'b0, w_pos[3]} + 1'b1;
        o_next_pos = (inc == POOL_END) ? '0 : inc[PW-1:0];
    end

    // per-cell next value: direct write or add of the matching crc byte
    always_comb begin
        logic [kcpm_pkg::BYTE_W-1:0] add;
        logic                        hit;
        for (int i = 0; i < POOL_BYTES; i++) begin
            add = '0;
            for (int k = 0; k < 4; k++) begin
                if (w_pos[k] == PW'(i)) begin
                    add = add | i_crc[kcpm_pkg::CRC_W-1-8*k -: 8];
                end
            end
            hit = ({26'd0, i_index} == 32'(i));
            if (i_cmd.wr && hit) begin
                n_pool[i] = i_wdata;
            end else if (i_cmd.mix) begin
                n_pool[i] = r_pool[i] + add;
            end else begin
                n_pool[i] = r_pool[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < POOL_BYTES; i++) begin
            if (!i_rst_n) begin
                r_pool[i] <= '0;
            end else begin
                r_pool[i] <= n_pool[i];
            end
        end
    end

    // readback; an index past the pool reads as zero
    always_comb begin
        o_rdata = '0;
        for (int i = 0; i < POOL_BYTES; i++) begin
            if ({26'd0, i_index} == 32'(i)) begin
                o_rdata = o_rdata | r_pool[i];
            end
        end
    end

endmodule

/* design/keyfile_crc_pool_mixer_top.sv */
// keyfile_crc_pool_mixer_top: control path, crc and length state, result register.
// Depends on kcpm_pkg, the three channel interfaces and kcpm_pool.
`timescale 1ns / 1ps

// Usage
//   i_in  : items of kind write pool byte, keyfile byte, end of keyfile and
//           read pool byte. Every item gives exactly one result item on o_out.
//   o_out : read_byte (pool entry for a read, else zero) and status
//           (ok, insufficient keyfile data at end, byte ignored past limit).
//   i_cfg : writes max_length (index 0) and min_length (index 1); always ready.
//           Write only while no item is in flight. Other indexes are dropped.
// Timing
//   An item is captured in the input register at the accepting edge; its result
//   is loaded into the output register when that register is free or being taken,
//   and is then shown on o_out. One item per cycle is sustained while o_out is not
//   stalled: the crc byte step and the four pool additions are all done
//   combinationally between the input register and the output register.
// Reset
//   Synchronous, active low: pool cleared to zero, crc register all ones,
//   position and byte count zero, length registers at their defaults, both
//   channel registers empty.
// Stall
//   While the output register holds an untaken result, the input register holds
//   its item; i_in.ready stays high as long as the input register can move on.

module keyfile_crc_pool_mixer_top #(
    parameter int POOL_BYTES = kcpm_pkg::POOL_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kcpm_in_if.sink     i_in,
    kcpm_out_if.source  o_out,
    kcpm_cfg_if.sink    i_cfg
);

    localparam int PW = $clog2(POOL_BYTES);

    // input register
    logic                                r_in_valid;
    kcpm_pkg::t_kind                     r_kind;
    logic [kcpm_pkg::INDEX_W-1:0]        r_idx;
    logic [kcpm_pkg::BYTE_W-1:0]         r_data;

    // per-file and configuration state
    logic [kcpm_pkg::CRC_W-1:0]          r_crc, n_crc;
    logic [PW-1:0]                       r_pos, n_pos;
    logic [kcpm_pkg::LEN_W-1:0]          r_count, n_count;
    logic [kcpm_pkg::LEN_W-1:0]          r_max_len;
    logic [kcpm_pkg::LEN_W-1:0]          r_min_len;

    // output register
    logic                                r_out_valid;
    logic [kcpm_pkg::BYTE_W-1:0]         r_read_byte, n_read_byte;
    kcpm_pkg::t_status                   r_status, n_status;

    logic                                w_fire;
    logic                                w_mix_ok;
    logic [kcpm_pkg::CRC_W-1:0]          w_crc_next;
    logic [PW-1:0]                       w_next_pos;
    logic [kcpm_pkg::BYTE_W-1:0]         w_rdata;
    kcpm_pkg::t_pool_cmd                 w_cmd;

    // handshake: the compute stage moves when the output register is free
    assign w_fire      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_fire;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.read_byte = r_read_byte;
    assign o_out.status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= kcpm_pkg::t_kind'(i_in.kind);
            r_idx  <= i_in.pool_index;
            r_data <= i_in.data_byte;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= kcpm_pkg::MAX_LENGTH_RST;
            r_min_len <= kcpm_pkg::MIN_LENGTH_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                kcpm_pkg::CFG_MAX_LENGTH: r_max_len <= i_cfg.data;
                kcpm_pkg::CFG_MIN_LENGTH: r_min_len <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_mix_ok   = (r_count < r_max_len);
    assign w_crc_next = kcpm_pkg::crc_byte(r_crc, r_data);

    // pool commands for the item in the input register
    always_comb begin
        w_cmd.wr  = w_fire && (r_kind == kcpm_pkg::KIND_WRITE);
        w_cmd.mix = w_fire && (r_kind == kcpm_pkg::KIND_KEY) && w_mix_ok;
    end

    kcpm_pool #(
        .POOL_BYTES (POOL_BYTES)
    ) u_pool (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_index    (r_idx),
        .i_wdata    (r_data),
        .i_pos      (r_pos),
        .i_crc      (w_crc_next),
        .o_next_pos (w_next_pos),
        .o_rdata    (w_rdata)
    );

    // per-file state update and result for the current item
    always_comb begin
        n_crc       = r_crc;
        n_pos       = r_pos;
        n_count     = r_count;
        n_read_byte = '0;
        n_status    = kcpm_pkg::ST_OK;
        case (r_kind)
            kcpm_pkg::KIND_WRITE: ;
            kcpm_pkg::KIND_KEY: begin
                if (w_mix_ok) begin
                    n_crc   = w_crc_next;
                    n_pos   = w_next_pos;
                    n_count = r_count + 1'b1;
                end else begin
                    n_status = kcpm_pkg::ST_IGNORED;
                end
            end
            kcpm_pkg::KIND_END: begin
                if (r_count < r_min_len) begin
                    n_status = kcpm_pkg::ST_SHORT;
                end
                n_crc   = kcpm_pkg::CRC_INIT;
                n_pos   = '0;
                n_count = '0;
            end
            kcpm_pkg::KIND_READ: n_read_byte = w_rdata;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= kcpm_pkg::CRC_INIT;
            r_pos   <= '0;
            r_count <= '0;
        end else if (w_fire) begin
            r_crc   <= n_crc;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_byte <= n_read_byte;
            r_status    <= n_status;
        end
    end

endmodule

/* design/kcpm_checker.sv */
// kcpm_checker: port-level assertions for keyfile_crc_pool_mixer_top, bound to it
// below. Depends on kcpm_pkg for widths and status codes.
`timescale 1ns / 1ps

module kcpm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [kcpm_pkg::BYTE_W-1:0]       i_read_byte,
    input logic [kcpm_pkg::STATUS_W-1:0]     i_status
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_read_byte) && $stable(i_status))
        else $error("result changed while stalled");

    // only a stalled output may hold back the input channel
    a_in_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input not ready without output stall");

    // a nonzero read byte comes only with an ok status
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_read_byte != '0) |-> i_status == kcpm_pkg::ST_OK)
        else $error("read byte with error status");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind keyfile_crc_pool_mixer_top kcpm_checker u_kcpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_read_byte (o_out.read_byte),
    .i_status    (o_out.status)
);
